[rtl/scaled_font_glyph_renderer_defines.svh]
// Assertion macros shared by the glyph renderer RTL.
// Included by sfgr_sequencer, the module that carries concurrent assertions; no other dependencies.
`ifndef SCALED_FONT_GLYPH_RENDERER_DEFINES_SVH
`define SCALED_FONT_GLYPH_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFGR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sfgr_pkg.sv]
// Shared types, register indexes and the 5x7 font table of the glyph renderer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfgr_pkg;

	// Glyph geometry
	localparam int GLYPH_FIRST = 32;
	localparam int GLYPH_LAST  = 126;
	localparam int GLYPH_COUNT = 95;
	localparam int GLYPH_COLS  = 5;
	localparam int ROM_DEPTH   = GLYPH_COUNT * GLYPH_COLS;
	localparam int ROM_AW      = $clog2(ROM_DEPTH);

	// Cell column index of the blank spacer column
	localparam logic [2:0] BLANK_COL = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_H_SCALE       = 2'd0;
	localparam logic [1:0] REG_V_SCALE       = 2'd1;
	localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;

	// Input actions
	localparam logic ACT_SET_CURSOR = 1'b0;
	localparam logic ACT_RENDER     = 1'b1;

	// Configuration register file contents
	typedef struct packed {
		logic [2:0] h_scale;
		logic [2:0] v_scale;
		logic [5:0] column_offset;
	} cfg_t;

	// One span write issued by the sequencer, on its way to the expand stage
	typedef struct packed {
		logic       valid;
		logic       blank;
		logic [1:0] row;
		logic [2:0] vsc;
		logic [2:0] page;
		logic [7:0] column;
		logic [2:0] span;
		logic       last;
	} issue_t;

	// Font table: five column bytes per glyph, codes 32..126, bit zero topmost
	localparam logic [7:0] FONT_ROM [0:ROM_DEPTH-1] = '{
		8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
		8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
		8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
		8'h36,8'h49,8'h56,8'h20,8'h50, 8'h00,8'h08,8'h07,8'h03,8'h00,
		8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
		8'h2A,8'h1C,8'h7F,8'h1C,8'h2A, 8'h08,8'h08,8'h3E,8'h08,8'h08,
		8'h00,8'h00,8'h70,8'h30,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
		8'h00,8'h00,8'h60,8'h60,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
		8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
		8'h72,8'h49,8'h49,8'h49,8'h46, 8'h21,8'h41,8'h49,8'h4D,8'h33,
		8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
		8'h3C,8'h4A,8'h49,8'h49,8'h31, 8'h41,8'h21,8'h11,8'h09,8'h07,
		8'h36,8'h49,8'h49,8'h49,8'h36, 8'h46,8'h49,8'h49,8'h29,8'h1E,
		8'h00,8'h00,8'h14,8'h00,8'h00, 8'h00,8'h40,8'h34,8'h00,8'h00,
		8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
		8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h59,8'h09,8'h06,
		8'h3E,8'h41,8'h5D,8'h59,8'h4E, 8'h7C,8'h12,8'h11,8'h12,8'h7C,
		8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
		8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41,
		8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h73,
		8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
		8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
		8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h1C,8'h02,8'h7F,
		8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
		8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
		8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h26,8'h49,8'h49,8'h49,8'h32,
		8'h03,8'h01,8'h7F,8'h01,8'h03, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
		8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
		8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
		8'h61,8'h59,8'h49,8'h4D,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h41,
		8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h41,8'h7F,
		8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
		8'h00,8'h03,8'h07,8'h08,8'h00, 8'h20,8'h54,8'h54,8'h38,8'h40,
		8'h7F,8'h28,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h28,
		8'h38,8'h44,8'h44,8'h28,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
		8'h00,8'h08,8'h7E,8'h09,8'h02, 8'h0C,8'h52,8'h52,8'h4A,8'h3C,
		8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00,
		8'h20,8'h40,8'h40,8'h3D,8'h00, 8'h7F,8'h10,8'h28,8'h44,8'h00,
		8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h78,8'h04,8'h78,
		8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
		8'h7C,8'h18,8'h24,8'h24,8'h18, 8'h18,8'h24,8'h24,8'h18,8'h7C,
		8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h24,
		8'h04,8'h04,8'h3F,8'h44,8'h24, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
		8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
		8'h44,8'h28,8'h10,8'h28,8'h44, 8'h4C,8'h50,8'h50,8'h50,8'h3C,
		8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
		8'h00,8'h00,8'h77,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
		8'h02,8'h01,8'h02,8'h04,8'h02
	};

endpackage

`default_nettype wire

[rtl/sfgr_font_rom.sv]
// Synchronous font ROM: one column byte per read, with registered read data.
// Depends on sfgr_pkg for the font table and its address width.
`default_nettype none

module sfgr_font_rom (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [sfgr_pkg::ROM_AW-1:0] rd_addr,
	output logic      [7:0]                  rd_data_s1
);
	import sfgr_pkg::*;

	// Registered read, held while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= FONT_ROM[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/sfgr_sequencer.sv]
// Input handshake, cursor state and the column/row sequencer that issues span writes.
// Depends on sfgr_pkg and the assertion macros in scaled_font_glyph_renderer_defines.svh.
`default_nettype none
`include "scaled_font_glyph_renderer_defines.svh"

module sfgr_sequencer #(
	parameter int DISPLAY_WIDTH = 96,
	parameter int PAGE_ROWS     = 5
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sfgr_pkg::cfg_t              cfg,
	input  wire logic                        adv,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire logic [6:0]                  char_code,
	input  wire logic [6:0]                  cursor_col,
	input  wire logic [2:0]                  cursor_page,
	output logic      [sfgr_pkg::ROM_AW-1:0] rom_addr,
	output sfgr_pkg::issue_t                 iss_s1
);
	import sfgr_pkg::*;

	localparam logic        [7:0] DW8 = 8'(DISPLAY_WIDTH);
	localparam logic signed [4:0] PR5 = 5'(PAGE_ROWS);

	logic       busy_q;
	logic [2:0] i_q;
	logic [1:0] j_q;
	logic [6:0] glyph_q;
	logic [2:0] item_h_q;
	logic [2:0] item_v_q;
	logic [7:0] cur_col_q;
	logic [2:0] cur_page_q;

	logic        in_acc;
	logic        row_last;
	logic        item_last;
	logic        fin;
	logic [6:0]  glyph_d;
	logic [4:0]  col_mul;
	logic [7:0]  base_col;
	logic [7:0]  col_step;
	logic [7:0]  col_sum;
	logic [4:0]  next_page;
	logic signed [4:0] page_bound;
	issue_t      iss;

	// Handshake: a new transaction enters as the current character issues its last write
	assign row_last  = ({1'b0, j_q} == (item_v_q - 3'd1));
	assign item_last = (i_q == BLANK_COL) && row_last;
	assign fin       = busy_q && item_last && adv;
	assign in_stall  = busy_q && !fin;
	assign in_acc    = in_valid && !in_stall;

	// Codes without a glyph map to space
	assign glyph_d = ((char_code >= 7'(GLYPH_FIRST)) && (char_code <= 7'(GLYPH_LAST))) ?
		(char_code - 7'(GLYPH_FIRST)) : 7'd0;

	// Font address: glyph * 5 + column
	assign rom_addr = (i_q == BLANK_COL) ? '0 :
		(ROM_AW'({glyph_q, 2'b00}) + ROM_AW'(glyph_q) + ROM_AW'(i_q));

	// Span write fields for the current column and page row
	assign col_mul  = {2'b00, i_q} * {2'b00, item_h_q};
	assign base_col = cur_col_q + {3'b000, col_mul};

	always_comb begin
		iss        = '0;
		iss.valid  = busy_q;
		iss.blank  = (i_q == BLANK_COL);
		iss.row    = j_q;
		iss.vsc    = item_v_q;
		iss.page   = cur_page_q + {1'b0, j_q};
		iss.column = base_col + {2'b00, cfg.column_offset};
		iss.span   = item_h_q;
		iss.last   = item_last;
	end

	// Cursor advance: six cell columns per character, wrap to the next text line
	assign col_step   = ({5'b0, item_h_q} << 2) + ({5'b0, item_h_q} << 1);
	assign col_sum    = cur_col_q + col_step;
	assign next_page  = {2'b00, cur_page_q} + {2'b00, item_v_q};
	assign page_bound = PR5 - $signed({2'b00, item_v_q});

	// Sequencer counters and per-character latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (in_acc && (action == ACT_RENDER)) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= '0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && adv) begin
			if (row_last) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (action == ACT_RENDER)) begin
			glyph_q  <= glyph_d;
			item_h_q <= cfg.h_scale;
			item_v_q <= cfg.v_scale;
		end
	end

	// Cursor registers; a set-cursor transaction overrides the advance of the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_page_q <= '0;
		end else if (in_acc && (action == ACT_SET_CURSOR)) begin
			cur_col_q  <= {1'b0, cursor_col};
			cur_page_q <= cursor_page;
		end else if (fin) begin
			if (col_sum >= DW8) begin
				cur_col_q <= '0;
				if ($signed(next_page) >= page_bound) begin
					cur_page_q <= '0;
				end else begin
					cur_page_q <= next_page[2:0];
				end
			end else begin
				cur_col_q <= col_sum;
			end
		end
	end

	// Issue register, aligned with the font ROM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
		end else if (adv) begin
			iss_s1 <= iss;
		end
	end

	// Checks
	`SFGR_ASSERT_NOW(a_cnt_range, clk, arst_n, busy_q,
		(i_q <= BLANK_COL) && ({1'b0, j_q} < item_v_q), "sequencer counter out of range")
	`SFGR_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, busy_q && !adv,
		busy_q && $stable(i_q) && $stable(j_q), "sequencer moved while stalled")
	`SFGR_ASSERT_NEXT(a_start, clk, arst_n, in_acc && (action == ACT_RENDER),
		busy_q && (i_q == 3'd0) && (j_q == 2'd0), "render did not start at column zero")
	`SFGR_ASSERT_NEXT(a_finish, clk, arst_n, fin && !(in_acc && (action == ACT_RENDER)),
		!busy_q, "sequencer still busy after final write")

endmodule

`default_nettype wire

[rtl/sfgr_expand.sv]
// Column expand stage: vertical bit replication, page byte select and output register.
// Depends on sfgr_pkg for the issue record.
`default_nettype none

module sfgr_expand (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire sfgr_pkg::issue_t iss_s1,
	input  wire logic [7:0]       rd_data_s1,
	output logic                  out_valid,
	output logic      [2:0]       page,
	output logic      [7:0]       column,
	output logic      [7:0]       pixels,
	output logic      [2:0]       span,
	output logic                  last
);
	import sfgr_pkg::*;

	// Repeat every bit of a column byte v times
	function automatic logic [31:0] stretch(input logic [7:0] c, input logic [2:0] v);
		logic [31:0] w;
		w = '0;
		for (int b = 0; b < 8; b++) begin
			case (v)
				3'd2: w[2*b +: 2] = {2{c[b]}};
				3'd3: w[3*b +: 3] = {3{c[b]}};
				3'd4: w[4*b +: 4] = {4{c[b]}};
				default: w[b] = c[b];
			endcase
		end
		return w;
	endfunction

	logic [7:0]  col_byte;
	logic [31:0] word;
	logic        valid_s2;
	logic [2:0]  page_s2;
	logic [7:0]  column_s2;
	logic [7:0]  pixels_s2;
	logic [2:0]  span_s2;
	logic        last_s2;

	// Glyph column shifted down one pixel; spacer column is empty
	assign col_byte = iss_s1.blank ? 8'h00 : {rd_data_s1[6:0], 1'b0};
	assign word     = stretch(col_byte, iss_s1.vsc);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= iss_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			page_s2   <= iss_s1.page;
			column_s2 <= iss_s1.column;
			pixels_s2 <= word[{iss_s1.row, 3'b000} +: 8];
			span_s2   <= iss_s1.span;
			last_s2   <= iss_s1.last;
		end
	end

	assign out_valid = valid_s2;
	assign page      = page_s2;
	assign column    = column_s2;
	assign pixels    = pixels_s2;
	assign span      = span_s2;
	assign last      = last_s2;

endmodule

`default_nettype wire

[rtl/scaled_font_glyph_renderer.sv]
// Top level of the scaled 5x7 font glyph renderer: configuration registers and pipeline.
// Depends on sfgr_pkg, sfgr_font_rom, sfgr_sequencer and sfgr_expand.
`default_nettype none

// A render transaction produces 6 x v_scale span writes, one per clock while the output
// is not stalled: the sequencer steps over five glyph columns plus a blank spacer column,
// and over v_scale page rows within each, reading one byte a cycle from a synchronous font
// ROM. A set-cursor transaction produces no output. Results are registered in the ROM read,
// then in the output register. The next transaction is taken in the cycle the last write
// of the current character issues, so characters stream without gaps. Scale registers are
// clamped to 1..4 on write. There is no clearing pass after reset.
module scaled_font_glyph_renderer #(
	parameter int DISPLAY_WIDTH = 96,
	parameter int PAGE_ROWS     = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration write port
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       action,
	input  wire logic [6:0] char_code,
	input  wire logic [6:0] cursor_col,
	input  wire logic [2:0] cursor_page,
	// output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [2:0] page,
	output logic      [7:0] column,
	output logic      [7:0] pixels,
	output logic      [2:0] span,
	output logic            last
);
	import sfgr_pkg::*;

	cfg_t              cfg_q;
	logic              adv;
	logic [2:0]        scale_wr;
	logic [ROM_AW-1:0] rom_addr;
	logic [7:0]        rd_data_s1;
	issue_t            iss_s1;

	// Whole pipeline moves when the output register is free or being drained
	assign adv = !out_valid || !out_stall;

	// Scale writes clamp to 1..4
	always_comb begin
		scale_wr = cfg_data[2:0];
		if (cfg_data[2:0] == 3'd0) begin
			scale_wr = 3'd1;
		end else if (cfg_data[2:0] > 3'd4) begin
			scale_wr = 3'd4;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.h_scale       <= 3'd1;
			cfg_q.v_scale       <= 3'd1;
			cfg_q.column_offset <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_H_SCALE:       cfg_q.h_scale       <= scale_wr;
				REG_V_SCALE:       cfg_q.v_scale       <= scale_wr;
				REG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	sfgr_sequencer #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH),
		.PAGE_ROWS    (PAGE_ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.adv        (adv),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.char_code  (char_code),
		.cursor_col (cursor_col),
		.cursor_page(cursor_page),
		.rom_addr   (rom_addr),
		.iss_s1     (iss_s1)
	);

	sfgr_font_rom u_rom (
		.clk       (clk),
		.rd_en     (adv),
		.rd_addr   (rom_addr),
		.rd_data_s1(rd_data_s1)
	);

	sfgr_expand u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.iss_s1    (iss_s1),
		.rd_data_s1(rd_data_s1),
		.out_valid (out_valid),
		.page      (page),
		.column    (column),
		.pixels    (pixels),
		.span      (span),
		.last      (last)
	);

endmodule

`default_nettype wire
